[hdl/ycrs_pkg.sv]
// Shared types, conversion constants and register indexes for the YCbCr to RGB core.
`default_nettype none

package ycrs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_H_SHIFT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_V_SHIFT = 2'd3;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [1:0]  RST_CHROMA_SHIFT = 2'd1;
    localparam logic [1:0]  MAX_CHROMA_SHIFT = 2'd2;

    localparam logic [17:0] K_Y    = 18'd298;
    localparam logic [17:0] K_R_CR = 18'd409;
    localparam logic [17:0] K_G_CB = 18'd100;
    localparam logic [17:0] K_G_CR = 18'd208;
    localparam logic [17:0] K_B_CB = 18'd516;

    localparam logic signed [19:0] OFF_R = 20'sd57088;
    localparam logic signed [19:0] OFF_G = 20'sd34816;
    localparam logic signed [19:0] OFF_B = 20'sd70912;

    localparam logic signed [19:0] CLAMP_HI = 20'sd65535;

    typedef struct packed {
        logic origin;
        logic eol;
        logic eof;
    } t_pos_flags;

    function automatic logic [7:0] clamp_channel(input logic signed [19:0] s);
        logic [7:0] res;
        if (s < 20'sd0) begin
            res = 8'd0;
        end else if (s > CLAMP_HI) begin
            res = 8'hff;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    function automatic logic [1:0] sat_shift(input logic [1:0] s);
        return (s > MAX_CHROMA_SHIFT) ? MAX_CHROMA_SHIFT : s;
    endfunction

endpackage

`default_nettype wire

[hdl/ycrs_raster.sv]
// Raster position tracker: column/row counters, chroma cell origin and line/frame end flags.
`default_nettype none

module ycrs_raster
    import ycrs_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic [11:0]                   i_frame_width,
    input  wire logic [11:0]                   i_frame_height,
    input  wire logic [1:0]                    i_h_shift,
    input  wire logic [1:0]                    i_v_shift,
    output logic      [$clog2(MAX_WIDTH)-1:0]  o_line_idx,
    output t_pos_flags                         o_flags
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = (WW > 12) ? WW : 12;
    localparam int CMPH = (HW > 12) ? HW : 12;

    localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);
    localparam logic [CMPH-1:0] MAX_H_C = CMPH'(MAX_HEIGHT);

    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [CMPW-1:0] fw_ext, w_last;
    logic [CMPH-1:0] fh_ext, h_last;
    logic [1:0]      hs, vs;
    logic [CW-1:0]   hmask;
    logic [RW-1:0]   vmask;
    logic            eol, eof;

    always_comb begin
        fw_ext = CMPW'(i_frame_width);
        fh_ext = CMPH'(i_frame_height);
        if (fw_ext == '0) begin
            w_last = '0;
        end else if (fw_ext > MAX_W_C) begin
            w_last = MAX_W_C - CMPW'(1);
        end else begin
            w_last = fw_ext - CMPW'(1);
        end
        if (fh_ext == '0) begin
            h_last = '0;
        end else if (fh_ext > MAX_H_C) begin
            h_last = MAX_H_C - CMPH'(1);
        end else begin
            h_last = fh_ext - CMPH'(1);
        end

        hs    = sat_shift(i_h_shift);
        vs    = sat_shift(i_v_shift);
        hmask = ~({CW{1'b1}} << hs);
        vmask = ~({RW{1'b1}} << vs);

        eol = CMPW'(r_col) >= w_last;
        eof = eol && (CMPH'(r_row) >= h_last);

        o_line_idx     = r_col >> hs;
        o_flags.origin = ((r_col & hmask) == '0) && ((r_row & vmask) == '0);
        o_flags.eol    = eol;
        o_flags.eof    = eof;

        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (eol) begin
                n_col = '0;
                n_row = eof ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

[hdl/ycbcr_to_rgb_subsampled_core.sv]
// Top level: subsampled YCbCr pixel stream to 8-bit RGB with a chroma line store.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  pixel   | in        | i_valid / o_stall      | i_luma, i_chroma_blue, i_chroma_red
//  rgb     | out       | o_valid / i_stall      | o_red, o_green, o_blue,
//          |           |                        | o_end_of_line, o_end_of_frame
//  config  | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One pixel per clock sustained while the output is not stalled; a pixel reaches the
//  output register through three stages: line store read, constant multiplies,
//  sum and clamp.
//  The line store is one synchronous read-modify-write memory per chroma plane.
//  Synchronous active-low reset clears counters and valids and restores config defaults.
//  An output stall backs up the stages in turn; empty stages still take pixels.
`default_nettype none

module ycbcr_to_rgb_subsampled_core
    import ycrs_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_luma,
    input  wire logic [7:0]            i_chroma_blue,
    input  wire logic [7:0]            i_chroma_red,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [7:0]            o_red,
    output logic      [7:0]            o_green,
    output logic      [7:0]            o_blue,
    output logic                       o_end_of_line,
    output logic                       o_end_of_frame,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [11:0] r_frame_width, r_frame_height;
    logic [1:0]  r_h_shift, r_v_shift;

    logic            accept;
    logic            rdy1, rdy2, rdy3;
    logic [CW-1:0]   line_idx;
    t_pos_flags      pos;

    logic [7:0] mem_cb [MAX_WIDTH];
    logic [7:0] mem_cr [MAX_WIDTH];

    logic       r_v1;
    logic [7:0] r1_y, r1_cb_in, r1_cr_in, r1_cb_rd, r1_cr_rd;
    logic       r1_origin, r1_eol, r1_eof;
    logic [7:0] cb_sel, cr_sel;

    logic        r_v2;
    logic [16:0] r2_my;
    logic [16:0] r2_r_cr;
    logic [14:0] r2_g_cb;
    logic [15:0] r2_g_cr;
    logic [17:0] r2_b_cb;
    logic        r2_eol, r2_eof;

    logic signed [19:0] sum_r, sum_g, sum_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_h_shift      <= RST_CHROMA_SHIFT;
            r_v_shift      <= RST_CHROMA_SHIFT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data;
                REG_CHROMA_H_SHIFT: r_h_shift      <= i_cfg_data[1:0];
                REG_CHROMA_V_SHIFT: r_v_shift      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign rdy3    = !o_valid || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign accept  = i_valid && rdy1;

    ycrs_raster #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (accept),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_h_shift      (r_h_shift),
        .i_v_shift      (r_v_shift),
        .o_line_idx     (line_idx),
        .o_flags        (pos)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (pos.origin) begin
                mem_cb[line_idx] <= i_chroma_blue;
                mem_cr[line_idx] <= i_chroma_red;
            end
            r1_cb_rd <= mem_cb[line_idx];
            r1_cr_rd <= mem_cr[line_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_y      <= i_luma;
            r1_cb_in  <= i_chroma_blue;
            r1_cr_in  <= i_chroma_red;
            r1_origin <= pos.origin;
            r1_eol    <= pos.eol;
            r1_eof    <= pos.eof;
        end
    end

    assign cb_sel = r1_origin ? r1_cb_in : r1_cb_rd;
    assign cr_sel = r1_origin ? r1_cr_in : r1_cr_rd;

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            r2_my   <= 17'(K_Y * r1_y);
            r2_r_cr <= 17'(K_R_CR * cr_sel);
            r2_g_cb <= 15'(K_G_CB * cb_sel);
            r2_g_cr <= 16'(K_G_CR * cr_sel);
            r2_b_cb <= 18'(K_B_CB * cb_sel);
            r2_eol  <= r1_eol;
            r2_eof  <= r1_eof;
        end
    end

    always_comb begin
        sum_r = $signed({3'b000, r2_my}) + $signed({3'b000, r2_r_cr}) - OFF_R;
        sum_g = $signed({3'b000, r2_my}) - $signed({5'b00000, r2_g_cb})
              - $signed({4'b0000, r2_g_cr}) + OFF_G;
        sum_b = $signed({3'b000, r2_my}) + $signed({2'b00, r2_b_cb}) - OFF_B;
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            o_red          <= clamp_channel(sum_r);
            o_green        <= clamp_channel(sum_g);
            o_blue         <= clamp_channel(sum_b);
            o_end_of_line  <= r2_eol;
            o_end_of_frame <= r2_eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                o_valid <= r_v2;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/ycrs_chk.sv]
// Port-level checker for the YCbCr to RGB core, bound to the top level.
`default_nettype none

module ycrs_chk
    import ycrs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [7:0]            o_red,
    input wire logic [7:0]            o_green,
    input wire logic [7:0]            o_blue,
    input wire logic                  o_end_of_line,
    input wire logic                  o_end_of_frame,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready
);

    a_eof_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_end_of_frame || o_end_of_line))
        else $error("end of frame without end of line");

    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_end_of_line) && $stable(o_end_of_frame)))
        else $error("stalled result changed");

    a_stall_needs_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output moves");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind ycbcr_to_rgb_subsampled_core ycrs_chk u_ycrs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_red          (o_red),
    .o_green        (o_green),
    .o_blue         (o_blue),
    .o_end_of_line  (o_end_of_line),
    .o_end_of_frame (o_end_of_frame),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);

`default_nettype wire
